FILE: src/kvt_pkg.sv
// shared types, codes and defaults for the key/value table
`default_nettype none

package kvt_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_ERASE  = 3'd1,
        ACT_LOOKUP = 3'd2,
        ACT_COUNT  = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_DUP     = 2'd2,
        STAT_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_RD_LAST,
        S_WR_MOVE,
        S_WR_INS,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [VALUE_W-1:0]  value_out;
        logic [CNT_W-1:0]    match_count;
        logic [CNT_W-1:0]    item_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic    take;
        logic    scan_en;
        logic    rd_last;
        logic    wr_move;
        logic    wr_ins;
        logic    clear_tbl;
        logic    load_out;
        t_status status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                scan_done;
        logic                hit;
        logic                full;
        logic                out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: src/kvt_dpath.sv
// key/value stores, scan pipeline, entry count and result register
`default_nettype none

module kvt_dpath #(
    parameter int TABLE_DEPTH = kvt_pkg::DEPTH_DEF,
    parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  kvt_pkg::t_in_item  i_in_item,
    input  wire                logic i_out_ready,
    input  kvt_pkg::t_cmd      i_cmd,
    output kvt_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output kvt_pkg::t_out_item o_out_item
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int EW  = CW + kvt_pkg::CNT_W;
    localparam int KIN = (KEY_BITS < kvt_pkg::KEY_W) ? KEY_BITS : kvt_pkg::KEY_W;
    localparam int VIN = (VALUE_BITS < kvt_pkg::VALUE_W) ? VALUE_BITS : kvt_pkg::VALUE_W;

    logic [KEY_BITS-1:0]   r_key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] r_val_mem [TABLE_DEPTH];

    kvt_pkg::t_in_item     r_item;
    logic [KEY_BITS-1:0]   r_key_rd;
    logic [VALUE_BITS-1:0] r_val_rd;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx;
    logic [AW-1:0]         r_cmp_idx;
    logic                  r_cmp_vld;
    logic                  r_hit;
    logic [AW-1:0]         r_slot;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_match;
    logic                  r_out_vld;
    kvt_pkg::t_out_item    r_out;

    logic [KEY_BITS-1:0]   key_in;
    logic [VALUE_BITS-1:0] val_in;
    logic [CW-1:0]         last_idx;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  wr_en;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    logic                  key_eq;
    logic                  val_eq;
    logic                  more;
    logic                  is_key_op;
    logic [EW-1:0]         cnt_ext;
    logic [EW-1:0]         match_ext;
    kvt_pkg::t_out_item    n_out;

    assign key_in    = KEY_BITS'(r_item.key[KIN-1:0]);
    assign val_in    = VALUE_BITS'(r_item.value[VIN-1:0]);
    assign last_idx  = r_count - CW'(1);
    assign more      = (r_idx < r_count);
    assign key_eq    = r_cmp_vld && (r_key_rd == key_in);
    assign val_eq    = r_cmp_vld && (r_val_rd == val_in);
    assign is_key_op = (r_item.action == kvt_pkg::ACT_INSERT) ||
                       (r_item.action == kvt_pkg::ACT_ERASE)  ||
                       (r_item.action == kvt_pkg::ACT_LOOKUP);

    assign rd_addr = i_cmd.rd_last ? last_idx[AW-1:0] : r_idx[AW-1:0];
    assign wr_en   = i_cmd.wr_ins || i_cmd.wr_move;
    assign wr_addr = i_cmd.wr_ins ? r_count[AW-1:0] : r_slot;
    assign wr_key  = i_cmd.wr_ins ? key_in : r_key_rd;
    assign wr_val  = i_cmd.wr_ins ? val_in : r_val_rd;

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[wr_addr] <= wr_key;
            r_val_mem[wr_addr] <= wr_val;
        end
        r_key_rd <= r_key_mem[rd_addr];
        r_val_rd <= r_val_mem[rd_addr];
    end

    always_comb begin
        n_count = r_count;
        priority if (i_cmd.clear_tbl) begin
            n_count = '0;
        end else if (i_cmd.wr_ins) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.wr_move) begin
            n_count = last_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // scan: issue a read, compare in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item  <= i_in_item;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_match <= '0;
        end else if (i_cmd.scan_en) begin
            if (more) begin
                r_idx <= r_idx + CW'(1);
            end
            if (key_eq && !r_hit) begin
                r_hit  <= 1'b1;
                r_slot <= r_cmp_idx;
                r_val  <= r_val_rd;
            end
            if (val_eq) begin
                r_match <= r_match + CW'(1);
            end
        end
        r_cmp_vld <= i_cmd.scan_en && more;
        r_cmp_idx <= r_idx[AW-1:0];
    end

    assign cnt_ext   = EW'(r_count);
    assign match_ext = EW'(r_match);

    always_comb begin
        n_out.status      = i_cmd.status;
        n_out.found       = r_hit && is_key_op;
        n_out.value_out   = (r_hit && (r_item.action == kvt_pkg::ACT_LOOKUP)) ?
                            kvt_pkg::VALUE_W'(r_val[VIN-1:0]) : '0;
        n_out.match_count = (r_item.action == kvt_pkg::ACT_COUNT) ?
                            match_ext[kvt_pkg::CNT_W-1:0] : '0;
        n_out.item_count  = cnt_ext[kvt_pkg::CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_sts.action    = r_item.action;
    assign o_sts.scan_done = (r_hit && is_key_op) || (!more && !r_cmp_vld);
    assign o_sts.hit       = r_hit;
    assign o_sts.full      = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

FILE: src/kvt_ctrl.sv
// controller state machine for the key/value table
`default_nettype none

module kvt_ctrl (
    input  wire           logic i_clk,
    input  wire           logic i_rst_n,
    input  wire           logic i_in_valid,
    output logic          o_in_ready,
    input  kvt_pkg::t_sts i_sts,
    output kvt_pkg::t_cmd o_cmd
);

    kvt_pkg::t_state  r_state, n_state;
    kvt_pkg::t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kvt_pkg::S_IDLE;
            r_status <= kvt_pkg::STAT_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        unique case (r_state)
            kvt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state  = kvt_pkg::S_DISPATCH;
                    n_status = kvt_pkg::STAT_OK;
                end
            end
            kvt_pkg::S_DISPATCH: begin
                unique case (i_sts.action)
                    kvt_pkg::ACT_INSERT,
                    kvt_pkg::ACT_ERASE,
                    kvt_pkg::ACT_LOOKUP,
                    kvt_pkg::ACT_COUNT: n_state = kvt_pkg::S_SCAN;
                    default:            n_state = kvt_pkg::S_RESULT;
                endcase
            end
            kvt_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = kvt_pkg::S_RESULT;
                    unique case (i_sts.action)
                        kvt_pkg::ACT_INSERT: begin
                            // full wins over duplicate
                            priority if (i_sts.full) begin
                                n_status = kvt_pkg::STAT_FULL;
                            end else if (i_sts.hit) begin
                                n_status = kvt_pkg::STAT_DUP;
                            end else begin
                                n_state = kvt_pkg::S_WR_INS;
                            end
                        end
                        kvt_pkg::ACT_ERASE: begin
                            if (i_sts.hit) begin
                                n_state = kvt_pkg::S_RD_LAST;
                            end else begin
                                n_status = kvt_pkg::STAT_MISSING;
                            end
                        end
                        kvt_pkg::ACT_LOOKUP: begin
                            if (!i_sts.hit) begin
                                n_status = kvt_pkg::STAT_MISSING;
                            end
                        end
                        default: begin
                            n_status = kvt_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            kvt_pkg::S_RD_LAST: n_state = kvt_pkg::S_WR_MOVE;
            kvt_pkg::S_WR_MOVE: n_state = kvt_pkg::S_RESULT;
            kvt_pkg::S_WR_INS:  n_state = kvt_pkg::S_RESULT;
            kvt_pkg::S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = kvt_pkg::S_IDLE;
                end
            end
            default: n_state = kvt_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = (r_state == kvt_pkg::S_IDLE);
        o_cmd.take      = (r_state == kvt_pkg::S_IDLE) && i_in_valid;
        o_cmd.scan_en   = (r_state == kvt_pkg::S_SCAN);
        o_cmd.rd_last   = (r_state == kvt_pkg::S_RD_LAST);
        o_cmd.wr_move   = (r_state == kvt_pkg::S_WR_MOVE);
        o_cmd.wr_ins    = (r_state == kvt_pkg::S_WR_INS);
        o_cmd.clear_tbl = (r_state == kvt_pkg::S_DISPATCH) &&
                          (i_sts.action == kvt_pkg::ACT_CLEAR);
        o_cmd.load_out  = (r_state == kvt_pkg::S_RESULT) && i_sts.out_free;
        o_cmd.status    = r_status;
    end

endmodule

`default_nettype wire

FILE: src/key_value_table.sv
// one item at a time; the scan uses the single read port of the key/value stores, one entry
//   compared per cycle up to the live count; insert and erase add a write-back, clear and
//   unused actions skip the scan
// reset: synchronous active-low i_rst_n empties the table and drops any pending result;
//   store contents are not cleared, only entries below the live count are ever read
`default_nettype none

module key_value_table #(
    parameter int TABLE_DEPTH = kvt_pkg::DEPTH_DEF,
    parameter int KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    // request item channel
    input  wire                logic i_in_valid,
    output logic               o_in_ready,
    input  kvt_pkg::t_in_item  i_in_item,
    // result item channel
    output logic               o_out_valid,
    input  wire                logic i_out_ready,
    output kvt_pkg::t_out_item o_out_item
);

    // command and status between controller and datapath
    kvt_pkg::t_cmd cmd;
    kvt_pkg::t_sts sts;

    // sequencing: dispatch, scan, optional write-back, result hand-off
    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // stores, compare pipeline, live count and result register
    kvt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // no store write while waiting for a new item
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(cmd.wr_ins || cmd.wr_move))
        else $error("store written while idle");

    // an append never happens on a full table
    a_no_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_ins |-> !sts.full)
        else $error("append on full table");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten");

    // one item in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while busy");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
// self-checking testbench for the key/value table: directed request table, then random traffic
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH    = kvt_pkg::DEPTH_DEF;
    localparam int KEY_W    = kvt_pkg::KEY_W;
    localparam int VALUE_W  = kvt_pkg::VALUE_W;
    localparam int CNT_W    = kvt_pkg::CNT_W;
    localparam int ACTION_W = kvt_pkg::ACTION_W;
    localparam int KEY_POOL = 40;   // more keys than slots, so full and duplicate both occur
    localparam int VAL_POOL = 6;

    // one row of the directed stimulus table
    typedef struct {
        kvt_pkg::t_in_item  req;
        bit                 typed;
        kvt_pkg::t_out_item res;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    kvt_pkg::t_in_item  in_item = '0;
    logic               out_ready = 1'b0;
    wire                o_in_ready;
    wire                o_out_valid;
    kvt_pkg::t_out_item o_out_item;

    // hand-written result travelling alongside the request item being offered
    bit                 has_typed = 1'b0;
    kvt_pkg::t_out_item typed_result = '0;

    // shadow copy of the table
    logic [KEY_W-1:0]   kv_keys [DEPTH];
    logic [VALUE_W-1:0] kv_vals [DEPTH];
    int                 kv_live = 0;

    kvt_pkg::t_out_item pending_results [$];

    logic [KEY_W-1:0]   key_pool [KEY_POOL];
    logic [VALUE_W-1:0] val_pool [VAL_POOL];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int hold_req = 0;
    int hold_done = 0;

    int errors = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_full = 0;
    int n_dup = 0;
    int n_missing = 0;
    int peak_count = 0;

    always #5 i_clk = ~i_clk;

    key_value_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item)
    );

    // applies one request to the shadow table and returns the result it must produce
    function automatic kvt_pkg::t_out_item kv_apply(kvt_pkg::t_in_item req);
        kvt_pkg::t_out_item res;
        int                 slot;
        int                 n_match;
        res = '0;
        slot = -1;
        n_match = 0;
        for (int i = 0; i < kv_live; i++) begin
            if (slot < 0 && kv_keys[i] == req.key) begin
                slot = i;
            end
        end
        case (req.action)
            kvt_pkg::ACT_INSERT: begin
                res.found = (slot >= 0);
                // fullness wins over the duplicate check
                if (kv_live >= DEPTH) begin
                    res.status = kvt_pkg::STAT_FULL;
                end else if (slot >= 0) begin
                    res.status = kvt_pkg::STAT_DUP;
                end else begin
                    kv_keys[kv_live] = req.key;
                    kv_vals[kv_live] = req.value;
                    kv_live++;
                end
            end
            kvt_pkg::ACT_ERASE: begin
                if (slot >= 0) begin
                    // swap-remove: the last live entry fills the hole
                    res.found = 1'b1;
                    kv_live--;
                    kv_keys[slot] = kv_keys[kv_live];
                    kv_vals[slot] = kv_vals[kv_live];
                end else begin
                    res.status = kvt_pkg::STAT_MISSING;
                end
            end
            kvt_pkg::ACT_LOOKUP: begin
                if (slot >= 0) begin
                    res.found = 1'b1;
                    res.value_out = kv_vals[slot];
                end else begin
                    res.status = kvt_pkg::STAT_MISSING;
                end
            end
            kvt_pkg::ACT_COUNT: begin
                for (int i = 0; i < kv_live; i++) begin
                    if (kv_vals[i] == req.value) begin
                        n_match++;
                    end
                end
                res.match_count = CNT_W'(n_match);
            end
            kvt_pkg::ACT_CLEAR: begin
                kv_live = 0;
            end
            default: begin
                // unused action codes leave the table alone
            end
        endcase
        res.item_count = CNT_W'(kv_live);
        return res;
    endfunction

    function automatic t_dir_row mk_row(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] k,
                                        logic [VALUE_W-1:0] v, bit typed,
                                        kvt_pkg::t_status st, logic fnd,
                                        logic [VALUE_W-1:0] vo, int mc, int ic);
        t_dir_row row;
        row.req = '{action: act, key: k, value: v};
        row.typed = typed;
        row.res = '{status: st, found: fnd, value_out: vo,
                    match_count: CNT_W'(mc), item_count: CNT_W'(ic)};
        return row;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 4) == 0) begin
            return $urandom;
        end
        return val_pool[$urandom_range(0, VAL_POOL-1)];
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // offers one request item, with a random gap in front while tx_idle is set, and returns once it is taken
    task automatic send_req(kvt_pkg::t_in_item req, bit typed, kvt_pkg::t_out_item res);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        has_typed <= typed;
        typed_result <= res;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        n_sent++;
    endtask

    // request acceptance and result checking, both sampled at the rising edge
    always @(posedge i_clk) begin : monitor
        kvt_pkg::t_out_item predicted;
        kvt_pkg::t_out_item want;
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                // the shadow table always advances, even when the row carries its own result
                predicted = kv_apply(in_item);
                pending_results.push_back(has_typed ? typed_result : predicted);
            end
            if (o_out_valid && out_ready) begin
                n_results++;
                if (o_out_item.status == kvt_pkg::STAT_FULL) n_full++;
                if (o_out_item.status == kvt_pkg::STAT_DUP) n_dup++;
                if (o_out_item.status == kvt_pkg::STAT_MISSING) n_missing++;
                if (int'(o_out_item.item_count) > peak_count) begin
                    peak_count = int'(o_out_item.item_count);
                end
                if (pending_results.size() == 0) begin
                    $error("result item with no request outstanding");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    report_field("status", want.status, o_out_item.status);
                    report_field("found", want.found, o_out_item.found);
                    report_field("value_out", want.value_out, o_out_item.value_out);
                    report_field("match_count", want.match_count, o_out_item.match_count);
                    report_field("item_count", want.item_count, o_out_item.item_count);
                end
            end
        end
    end

    // result side: random stall before each item while rx_idle is set, plus a long hold-off on request
    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        while (!rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            stall = rx_idle ? $urandom_range(0, 7) : 0;
            if (hold_req != hold_done) begin
                // long enough for the block to back up and refuse requests
                stall = 250;
                hold_done++;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) begin
                @(posedge i_clk);
            end
        end
    end

    // hard stop in case the block hangs
    initial begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : main_seq
        t_dir_row           dir_rows [$];
        kvt_pkg::t_in_item  req;
        kvt_pkg::t_out_item none;
        int                 start;
        int                 r;
        none = '0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) begin
            // low byte keeps pool keys distinct, upper bits random
            key_pool[i] = {24'($urandom), 8'(i)};
        end
        val_pool[0] = '0;
        val_pool[1] = '1;
        val_pool[2] = 32'h0000_0001;
        val_pool[3] = 32'h8000_0000;
        val_pool[4] = $urandom;
        val_pool[5] = $urandom;

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: empty table, extremes, duplicate, swap-remove, unused codes, clear
        dir_rows.push_back(mk_row(kvt_pkg::ACT_LOOKUP, 32'h0, 32'h0, 1,
                                  kvt_pkg::STAT_MISSING, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_ERASE, '1, 32'h0, 1,
                                  kvt_pkg::STAT_MISSING, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_COUNT, 32'h0, 32'h0, 1,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_INSERT, 32'h0, '1, 1,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 1));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_INSERT, '1, 32'h0, 1,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 2));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_INSERT, 32'h0, 32'h5, 1,
                                  kvt_pkg::STAT_DUP, 1, 0, 0, 2));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_LOOKUP, 32'h0, 32'h0, 1,
                                  kvt_pkg::STAT_OK, 1, '1, 0, 2));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_COUNT, 32'h0, '1, 1,
                                  kvt_pkg::STAT_OK, 0, 0, 1, 2));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_COUNT, '1, 32'h0, 1,
                                  kvt_pkg::STAT_OK, 0, 0, 1, 2));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_ERASE, 32'h0, 32'h0, 1,
                                  kvt_pkg::STAT_OK, 1, 0, 0, 1));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_LOOKUP, 32'h0, 32'h0, 1,
                                  kvt_pkg::STAT_MISSING, 0, 0, 0, 1));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_LOOKUP, '1, 32'h0, 1,
                                  kvt_pkg::STAT_OK, 1, 0, 0, 1));
        dir_rows.push_back(mk_row(3'd5, '1, '1, 1, kvt_pkg::STAT_OK, 0, 0, 0, 1));
        dir_rows.push_back(mk_row(3'd6, '1, '1, 1, kvt_pkg::STAT_OK, 0, 0, 0, 1));
        dir_rows.push_back(mk_row(3'd7, '1, '1, 1, kvt_pkg::STAT_OK, 0, 0, 0, 1));
        // the next six take their results from the shadow table
        dir_rows.push_back(mk_row(kvt_pkg::ACT_INSERT, 32'h5555_AAAA, 32'h1234_5678, 0,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_INSERT, 32'hAAAA_5555, 32'h1234_5678, 0,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_COUNT, 32'h0, 32'h1234_5678, 0,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 0));
        // erase the first entry, then the one that was last and now fills its slot
        dir_rows.push_back(mk_row(kvt_pkg::ACT_ERASE, '1, 32'h0, 0,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_LOOKUP, 32'hAAAA_5555, 32'h0, 0,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_ERASE, 32'hAAAA_5555, 32'h0, 0,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_CLEAR, '1, '1, 1,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 0));
        // stale store contents must not show after a clear
        dir_rows.push_back(mk_row(kvt_pkg::ACT_LOOKUP, 32'h5555_AAAA, 32'h0, 1,
                                  kvt_pkg::STAT_MISSING, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(kvt_pkg::ACT_COUNT, 32'h0, 32'h1234_5678, 1,
                                  kvt_pkg::STAT_OK, 0, 0, 0, 0));

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        end

        // random part: each episode clears, fills past capacity, then mixes all actions
        for (int ep = 0; ep < 6; ep++) begin
            tx_idle = (ep % 3) != 2;
            rx_idle = (ep % 3) != 1;
            if (ep == 1) begin
                // receiver stops for a long stretch while the fill is being offered
                hold_req++;
            end
            req = '{action: kvt_pkg::ACT_CLEAR, key: $urandom, value: $urandom};
            send_req(req, 0, none);
            start = $urandom_range(0, KEY_POOL-1);
            for (int i = 0; i < DEPTH + 2; i++) begin
                req.action = kvt_pkg::ACT_INSERT;
                req.key = key_pool[(start + i) % KEY_POOL];
                // first episode stores one value everywhere so a count can reach its top
                req.value = (ep == 0) ? val_pool[1] : pick_value();
                send_req(req, 0, none);
            end
            for (int i = 0; i < 65; i++) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    req.action = kvt_pkg::ACT_INSERT;
                end else if (r < 58) begin
                    req.action = kvt_pkg::ACT_ERASE;
                end else if (r < 80) begin
                    req.action = kvt_pkg::ACT_LOOKUP;
                end else if (r < 94) begin
                    req.action = kvt_pkg::ACT_COUNT;
                end else if (r < 97) begin
                    req.action = kvt_pkg::ACT_CLEAR;
                end else begin
                    req.action = 3'($urandom_range(5, 7));
                end
                req.key = ($urandom_range(0, 6) == 0) ? $urandom
                                                      : key_pool[$urandom_range(0, KEY_POOL-1)];
                req.value = (ep == 0 && $urandom_range(0, 1) == 0) ? val_pool[1] : pick_value();
                send_req(req, 0, none);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // a stray late result would still be caught in this window
        repeat (50) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, peak occupancy %0d of %0d",
                 n_sent, n_results, peak_count, DEPTH);
        $display("results seen: %0d table full, %0d duplicate key, %0d key not found",
                 n_full, n_dup, n_missing);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
